@@ sv/adsr_pkg.sv @@
// Shared types, constants and register codes for the ADSR envelope generator.
package adsr_pkg;

    // Default parameter values for the top level.
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int LEVEL_FRAC_BITS_DEF = 31;
    localparam int TIME_BITS_DEF       = 22;

    // Fixed field widths of the configuration and result fields.
    localparam int TIME_REG_W  = 23;
    localparam int SUS_W       = 24;
    localparam int LEVEL_OUT_W = 24;
    localparam int STAGE_W     = 3;
    localparam int CMD_W       = 2;

    // APB port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Sustain full scale in Q23.
    localparam logic [SUS_W-1:0] Q23_ONE = 24'd8388608;

    // Register reset values.
    localparam logic [TIME_REG_W-1:0] ATTACK_RST  = 23'd441;
    localparam logic [TIME_REG_W-1:0] DECAY_RST   = 23'd4410;
    localparam logic [SUS_W-1:0]      SUSTAIN_RST = 24'd5872026;
    localparam logic [TIME_REG_W-1:0] RELEASE_RST = 23'd8820;

    // Register indexes on the APB port.
    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } t_reg;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2,
        CMD_RST  = 2'd3
    } t_cmd;

    // Envelope stages.
    typedef enum logic [STAGE_W-1:0] {
        STG_IDLE    = 3'd0,
        STG_ATTACK  = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4
    } t_stage;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE = 3'd0,
        SQ_PREP = 3'd1,
        SQ_EXEC = 3'd2,
        SQ_WAIT = 3'd3,
        SQ_MUL  = 3'd4,
        SQ_OUT  = 3'd5
    } t_seq;

    // Which step register a quotient is written to.
    typedef enum logic [1:0] {
        TGT_ATK = 2'd0,
        TGT_DEC = 2'd1,
        TGT_REL = 2'd2
    } t_tgt;

endpackage

@@ sv/adsr_envelope_generator_unit.sv @@
// ADSR envelope generator: an accepted transaction passes the prepare, execute, multiply and output states.
// Note-on, note-off above zero and a tick that ends the attack add a divider pass in the wait state.
// Each step made stale by an attack, decay or sustain write adds a divider pass before execution.
// The next transaction is accepted the cycle after the result loads; a result stall holds the output state.
// Reset (i_rst_n low, synchronous) clears the envelope to idle at level zero.
// Registers return to their defaults and all steps to zero; there is no clearing pass.
module adsr_envelope_generator_unit import adsr_pkg::*; #(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_audio_in,
    input  logic                   i_block_end,

    // Result channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [LEVEL_OUT_W-1:0] o_level_out,
    output logic [SAMPLE_BITS-1:0] o_shaped_sample,
    output logic [STAGE_W-1:0]     o_stage_out,
    output logic                   o_block_last,

    // APB configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int TW = TIME_BITS + 1;
    localparam int CW = (TW > TIME_REG_W) ? TW : TIME_REG_W;
    localparam int PW = SAMPLE_BITS + LW + 1;
    localparam logic [LW-1:0] LVL_ONE = LW'(1) << LEVEL_FRAC_BITS;
    localparam logic [CW-1:0] TIME_MAX = CW'(1) << TIME_BITS;

    // Configuration registers.
    logic [TIME_REG_W-1:0] r_attack;
    logic [TIME_REG_W-1:0] r_decay;
    logic [SUS_W-1:0]      r_sustain;
    logic [TIME_REG_W-1:0] r_release;

    // Envelope state.
    t_seq              r_seq, n_seq;
    t_stage            r_stage, n_stage;
    logic [LW-1:0]     r_level, n_level;
    logic [LW-1:0]     r_atk_step, n_atk_step;
    logic [LW-1:0]     r_dec_step, n_dec_step;
    logic [LW-1:0]     r_rel_step, n_rel_step;
    logic              r_atk_dirty, n_atk_dirty;
    logic              r_dec_dirty, n_dec_dirty;
    logic              r_ret_mul, n_ret_mul;
    t_tgt              r_tgt, n_tgt;

    // Captured transaction and product.
    t_cmd                   r_cmd;
    logic [SAMPLE_BITS-1:0] r_audio;
    logic                   r_blk;
    logic signed [PW-1:0]   r_prod;

    // Output register.
    logic                   r_out_valid;
    logic [LEVEL_OUT_W-1:0] r_level_out;
    logic [SAMPLE_BITS-1:0] r_shaped;
    logic [STAGE_W-1:0]     r_stage_out;
    logic                   r_block_last;

    // Internal signals.
    logic                  in_acc;
    logic                  out_free;
    logic                  cfg_wr;
    t_reg                  cfg_idx;
    logic [SUS_W-1:0]      sus_q23;
    logic [LW-1:0]         sus_int;
    logic [LEVEL_OUT_W-1:0] lvl_q23;
    logic [LW:0]           atk_sum;
    logic [LW:0]           dec_lim;
    logic                  div_start;
    t_tgt                  div_tgt;
    logic [LW-1:0]         div_num;
    logic [TW-1:0]         div_den;
    logic                  div_done;
    logic [LW-1:0]         div_quot;
    logic [LW-1:0]         step_q;
    logic signed [PW-1:0]  prod;

    // Time register as a divisor: zero acts as one, and values are capped at full range.
    function automatic logic [TW-1:0] clamp_t(input logic [TIME_REG_W-1:0] t);
        logic [CW-1:0] te;
        te = CW'(t);
        if (t == '0) begin
            clamp_t = TW'(1);
        end else if (te > TIME_MAX) begin
            clamp_t = TW'(TIME_MAX);
        end else begin
            clamp_t = TW'(te);
        end
    endfunction

    // Handshakes.
    assign o_in_stall = (r_seq != SQ_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_idx    = t_reg'(paddr[3:2]);
    assign pready     = 1'b1;

    // Register readback.
    always_comb begin
        unique case (cfg_idx)
            REG_ATTACK:  prdata = APB_DATA_W'(r_attack);
            REG_DECAY:   prdata = APB_DATA_W'(r_decay);
            REG_SUSTAIN: prdata = APB_DATA_W'(r_sustain);
            REG_RELEASE: prdata = APB_DATA_W'(r_release);
            default:     prdata = '0;
        endcase
    end

    // Sustain level in Q23, saturated at one; converted to the internal format below.
    assign sus_q23 = (r_sustain > Q23_ONE) ? Q23_ONE : r_sustain;

    // Format conversions between Q23 and the internal level.
    generate
        if (LEVEL_FRAC_BITS >= 23) begin : g_wide_level
            assign sus_int = LW'(sus_q23) << (LEVEL_FRAC_BITS - 23);
            assign lvl_q23 = r_level[LEVEL_FRAC_BITS -: LEVEL_OUT_W];
        end else begin : g_narrow_level
            assign sus_int = LW'(sus_q23 >> (23 - LEVEL_FRAC_BITS));
            assign lvl_q23 = LEVEL_OUT_W'({r_level, {(23 - LEVEL_FRAC_BITS){1'b0}}});
        end
    endgenerate

    // Stage arithmetic and the quotient with its floor of one.
    assign atk_sum = {1'b0, r_level} + {1'b0, r_atk_step};
    assign dec_lim = {1'b0, sus_int} + {1'b0, r_dec_step};
    assign step_q  = (div_quot == '0) ? LW'(1) : div_quot;
    assign prod    = $signed(r_audio) * $signed({1'b0, r_level});

    // Divisor follows the step being computed.
    always_comb begin
        unique case (div_tgt)
            TGT_ATK: div_den = clamp_t(r_attack);
            TGT_DEC: div_den = clamp_t(r_decay);
            TGT_REL: div_den = clamp_t(r_release);
            default: div_den = TW'(1);
        endcase
    end

    adsr_div #(
        .NUM_W (LW),
        .DEN_W (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer next state.
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: if (in_acc) n_seq = SQ_PREP;
            SQ_PREP: n_seq = (r_atk_dirty || r_dec_dirty) ? SQ_WAIT : SQ_EXEC;
            SQ_EXEC: n_seq = div_start ? SQ_WAIT : SQ_MUL;
            SQ_WAIT: begin
                if (div_done) n_seq = r_ret_mul ? SQ_MUL : SQ_PREP;
            end
            SQ_MUL:  n_seq = SQ_OUT;
            SQ_OUT:  if (out_free) n_seq = SQ_IDLE;
            default: n_seq = SQ_IDLE;
        endcase
    end

    // Sequencer outputs: envelope updates and divider requests.
    always_comb begin
        n_stage     = r_stage;
        n_level     = r_level;
        n_atk_step  = r_atk_step;
        n_dec_step  = r_dec_step;
        n_rel_step  = r_rel_step;
        n_atk_dirty = r_atk_dirty;
        n_dec_dirty = r_dec_dirty;
        n_ret_mul   = r_ret_mul;
        n_tgt       = r_tgt;
        div_start   = 1'b0;
        div_tgt     = r_tgt;
        div_num     = '0;

        unique case (r_seq)
            // Refresh steps that a register write has made stale.
            SQ_PREP: begin
                if (r_atk_dirty) begin
                    div_start   = 1'b1;
                    div_tgt     = TGT_ATK;
                    div_num     = LVL_ONE;
                    n_atk_dirty = 1'b0;
                end else if (r_dec_dirty) begin
                    div_start   = 1'b1;
                    div_tgt     = TGT_DEC;
                    div_num     = LVL_ONE - sus_int;
                    n_dec_dirty = 1'b0;
                end
                n_ret_mul = 1'b0;
            end

            // Apply the command to the envelope.
            SQ_EXEC: begin
                n_ret_mul = 1'b1;
                unique case (r_cmd)
                    CMD_TICK: begin
                        unique case (r_stage)
                            STG_ATTACK: begin
                                if (atk_sum >= {1'b0, LVL_ONE}) begin
                                    n_level   = LVL_ONE;
                                    n_stage   = STG_DECAY;
                                    div_start = 1'b1;
                                    div_tgt   = TGT_DEC;
                                    div_num   = LVL_ONE - sus_int;
                                end else begin
                                    n_level = atk_sum[LW-1:0];
                                end
                            end
                            STG_DECAY: begin
                                if ({1'b0, r_level} <= dec_lim) begin
                                    n_level = sus_int;
                                    n_stage = STG_SUSTAIN;
                                end else begin
                                    n_level = r_level - r_dec_step;
                                end
                            end
                            STG_SUSTAIN: n_level = sus_int;
                            STG_RELEASE: begin
                                if (r_level <= r_rel_step) begin
                                    n_level = '0;
                                    n_stage = STG_IDLE;
                                end else begin
                                    n_level = r_level - r_rel_step;
                                end
                            end
                            default: begin
                                n_level = '0;
                                n_stage = STG_IDLE;
                            end
                        endcase
                    end
                    CMD_ON: begin
                        // Already at peak: go straight to decay.
                        if (r_level >= LVL_ONE) begin
                            n_level   = LVL_ONE;
                            n_stage   = STG_DECAY;
                            div_start = 1'b1;
                            div_tgt   = TGT_DEC;
                            div_num   = LVL_ONE - sus_int;
                        end else begin
                            n_stage   = STG_ATTACK;
                            div_start = 1'b1;
                            div_tgt   = TGT_ATK;
                            div_num   = LVL_ONE - r_level;
                        end
                    end
                    CMD_OFF: begin
                        // Ignored when idle; a silent envelope simply stops.
                        if (r_stage != STG_IDLE) begin
                            if (r_level == '0) begin
                                n_stage = STG_IDLE;
                            end else begin
                                n_stage   = STG_RELEASE;
                                div_start = 1'b1;
                                div_tgt   = TGT_REL;
                                div_num   = r_level;
                            end
                        end
                    end
                    CMD_RST: begin
                        n_level = '0;
                        n_stage = STG_IDLE;
                    end
                    default: begin
                        n_level = '0;
                        n_stage = STG_IDLE;
                    end
                endcase
            end

            // Store the finished quotient.
            SQ_WAIT: begin
                if (div_done) begin
                    unique case (r_tgt)
                        TGT_ATK: n_atk_step = step_q;
                        TGT_DEC: n_dec_step = step_q;
                        TGT_REL: n_rel_step = step_q;
                        default: n_rel_step = r_rel_step;
                    endcase
                end
            end

            default: begin
                n_ret_mul = r_ret_mul;
            end
        endcase

        if (div_start) begin
            n_tgt = div_tgt;
        end

        // Register writes mark the steps that depend on them.
        if (cfg_wr && cfg_idx == REG_ATTACK) begin
            n_atk_dirty = 1'b1;
        end
        if (cfg_wr && (cfg_idx == REG_DECAY || cfg_idx == REG_SUSTAIN)) begin
            n_dec_dirty = 1'b1;
        end
    end

    // Control and envelope state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_stage     <= STG_IDLE;
            r_level     <= '0;
            r_atk_step  <= '0;
            r_dec_step  <= '0;
            r_rel_step  <= '0;
            r_atk_dirty <= 1'b0;
            r_dec_dirty <= 1'b0;
            r_ret_mul   <= 1'b0;
            r_tgt       <= TGT_ATK;
        end else begin
            r_seq       <= n_seq;
            r_stage     <= n_stage;
            r_level     <= n_level;
            r_atk_step  <= n_atk_step;
            r_dec_step  <= n_dec_step;
            r_rel_step  <= n_rel_step;
            r_atk_dirty <= n_atk_dirty;
            r_dec_dirty <= n_dec_dirty;
            r_ret_mul   <= n_ret_mul;
            r_tgt       <= n_tgt;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_RST;
            r_decay   <= DECAY_RST;
            r_sustain <= SUSTAIN_RST;
            r_release <= RELEASE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ATTACK:  r_attack  <= pwdata[TIME_REG_W-1:0];
                REG_DECAY:   r_decay   <= pwdata[TIME_REG_W-1:0];
                REG_SUSTAIN: r_sustain <= pwdata[SUS_W-1:0];
                REG_RELEASE: r_release <= pwdata[TIME_REG_W-1:0];
                default:     r_release <= r_release;
            endcase
        end
    end

    // Transaction capture and the sample product.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_audio <= i_audio_in;
            r_blk   <= i_block_end;
        end
        if (r_seq == SQ_MUL) begin
            r_prod <= (r_cmd == CMD_TICK) ? prod : '0;
        end
    end

    // Output register: valid flag under reset, payload loaded when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_seq == SQ_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == SQ_OUT && out_free) begin
            r_level_out  <= lvl_q23;
            r_shaped     <= r_prod[LEVEL_FRAC_BITS + SAMPLE_BITS - 1 : LEVEL_FRAC_BITS];
            r_stage_out  <= r_stage;
            r_block_last <= r_blk;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_out     = r_level_out;
    assign o_shaped_sample = r_shaped;
    assign o_stage_out     = r_stage_out;
    assign o_block_last    = r_block_last;

`ifndef SYNTHESIS
    // An accepted transaction closes the input until its result is loaded.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a transaction");

    // The level never goes above full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_ONE)
        else $error("envelope level above one");

    // An idle envelope is silent.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == STG_IDLE) |-> (r_level == '0))
        else $error("idle stage with nonzero level");

    // A quotient only arrives while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_seq == SQ_WAIT))
        else $error("divider finished outside the wait state");

    // A new result appears only from the output state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_seq == SQ_OUT))
        else $error("result raised outside the output state");
`endif

endmodule

@@ sv/adsr_div.sv @@
// Iterative restoring divider shared by all envelope step computations.
module adsr_div import adsr_pkg::*; #(
    parameter int NUM_W = LEVEL_FRAC_BITS_DEF + 1,
    parameter int DEN_W = TIME_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One quotient bit per cycle: shift in the next dividend bit and try to subtract.
    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    // Control: busy while the counter runs down from NUM_W, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend register doubles as the quotient register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], fits};
            r_rem  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ verif/adsr_checker.sv @@
// Checker for the ADSR envelope generator: watches all ports, predicts each result and compares.
`timescale 1ns / 100ps

module adsr_checker import adsr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // Input channel as seen at the block.
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic [SAMPLE_BITS_DEF-1:0] i_audio_in,
    input  logic                       i_block_end,

    // Result channel as seen at the block.
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [LEVEL_OUT_W-1:0]     i_level_out,
    input  logic [SAMPLE_BITS_DEF-1:0] i_shaped_sample,
    input  logic [STAGE_W-1:0]         i_stage_out,
    input  logic                       i_block_last,

    // Configuration port.
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [APB_ADDR_W-1:0]      i_paddr,
    input  logic [APB_DATA_W-1:0]      i_pwdata,
    input  logic [APB_DATA_W-1:0]      i_prdata,
    input  logic                       i_pready,

    output int                         o_fail_count
);

    // Level full scale, time clamp and the shift between Q23 and the internal level.
    localparam logic [32:0] LEVEL_ONE = 33'd1 << LEVEL_FRAC_BITS_DEF;
    localparam logic [32:0] TIME_CAP  = 33'd1 << TIME_BITS_DEF;
    localparam int          Q23_SHIFT = LEVEL_FRAC_BITS_DEF - 23;

    // One expected result transaction.
    typedef struct packed {
        logic [LEVEL_OUT_W-1:0]     level;
        logic [SAMPLE_BITS_DEF-1:0] shaped;
        t_stage                     stage;
        logic                       last;
    } t_envelope_result;

    t_envelope_result            expected_results[$];
    int                          mismatches = 0;

    // Predicted configuration.
    logic [TIME_REG_W-1:0]       attack_len;
    logic [TIME_REG_W-1:0]       decay_len;
    logic [SUS_W-1:0]            sustain_q23;
    logic [TIME_REG_W-1:0]       release_len;

    // Predicted envelope state; the increments are step magnitudes.
    t_stage                      env_stage;
    logic [31:0]                 env_level;
    logic [32:0]                 atk_inc;
    logic [32:0]                 dec_inc;
    logic [32:0]                 rel_inc;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Quotient of a distance by a clamped time, never below one level unit.
    function automatic logic [32:0] step_rate(input logic [32:0] delta,
                                              input logic [TIME_REG_W-1:0] len);
        logic [32:0] span;
        logic [32:0] quot;
        if (len == '0) begin
            span = 33'd1;
        end else if (33'(len) > TIME_CAP) begin
            span = TIME_CAP;
        end else begin
            span = 33'(len);
        end
        quot = delta / span;
        return (quot == '0) ? 33'd1 : quot;
    endfunction

    // Sustain target in level units, saturated at full scale.
    function automatic logic [32:0] sustain_target();
        logic [SUS_W-1:0] sat;
        sat = (sustain_q23 > Q23_ONE) ? Q23_ONE : sustain_q23;
        return 33'(sat) << Q23_SHIFT;
    endfunction

    function automatic void restart_decay();
        dec_inc = step_rate(LEVEL_ONE - sustain_target(), decay_len);
    endfunction

    function automatic void reset_envelope();
        attack_len  = ATTACK_RST;
        decay_len   = DECAY_RST;
        sustain_q23 = SUSTAIN_RST;
        release_len = RELEASE_RST;
        env_stage   = STG_IDLE;
        env_level   = '0;
        atk_inc     = '0;
        dec_inc     = '0;
        rel_inc     = '0;
    endfunction

    // Register writes; the attack, decay and sustain registers also refresh a step.
    function automatic void write_register(input t_reg idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_ATTACK: begin
                attack_len = value[TIME_REG_W-1:0];
                atk_inc    = step_rate(LEVEL_ONE, attack_len);
            end
            REG_DECAY: begin
                decay_len = value[TIME_REG_W-1:0];
                restart_decay();
            end
            REG_SUSTAIN: begin
                sustain_q23 = value[SUS_W-1:0];
                restart_decay();
            end
            default: begin
                release_len = value[TIME_REG_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] register_value(input t_reg idx);
        case (idx)
            REG_ATTACK:  return APB_DATA_W'(attack_len);
            REG_DECAY:   return APB_DATA_W'(decay_len);
            REG_SUSTAIN: return APB_DATA_W'(sustain_q23);
            default:     return APB_DATA_W'(release_len);
        endcase
    endfunction

    // Advances the envelope by one command and returns the result it produces.
    function automatic t_envelope_result apply_command(input t_cmd cmd,
                                                       input logic [SAMPLE_BITS_DEF-1:0] audio,
                                                       input logic last);
        logic [33:0]      sum;
        logic [32:0]      sus;
        longint           product;
        longint           scaled;
        t_envelope_result res;
        sus    = sustain_target();
        scaled = 0;
        case (cmd)
            CMD_TICK: begin
                case (env_stage)
                    STG_ATTACK: begin
                        sum = 34'(env_level) + 34'(atk_inc);
                        if (sum >= 34'(LEVEL_ONE)) begin
                            env_level = LEVEL_ONE[31:0];
                            env_stage = STG_DECAY;
                            restart_decay();
                        end else begin
                            env_level = sum[31:0];
                        end
                    end
                    STG_DECAY: begin
                        if (34'(env_level) <= 34'(sus) + 34'(dec_inc)) begin
                            env_level = sus[31:0];
                            env_stage = STG_SUSTAIN;
                        end else begin
                            env_level = env_level - dec_inc[31:0];
                        end
                    end
                    STG_SUSTAIN: begin
                        env_level = sus[31:0];
                    end
                    STG_RELEASE: begin
                        if (33'(env_level) <= rel_inc) begin
                            env_level = '0;
                            env_stage = STG_IDLE;
                        end else begin
                            env_level = env_level - rel_inc[31:0];
                        end
                    end
                    default: begin
                        env_stage = STG_IDLE;
                        env_level = '0;
                    end
                endcase
                // The sample is scaled by the new level and rounded toward minus infinity.
                if (env_stage != STG_IDLE || env_level != '0) begin
                    product = longint'($signed(audio)) * longint'({32'b0, env_level});
                    scaled  = product >>> LEVEL_FRAC_BITS_DEF;
                end
            end
            CMD_ON: begin
                if (33'(env_level) >= LEVEL_ONE) begin
                    env_level = LEVEL_ONE[31:0];
                    env_stage = STG_DECAY;
                    restart_decay();
                end else begin
                    atk_inc   = step_rate(LEVEL_ONE - 33'(env_level), attack_len);
                    env_stage = STG_ATTACK;
                end
            end
            CMD_OFF: begin
                if (env_stage != STG_IDLE) begin
                    if (env_level == '0) begin
                        env_stage = STG_IDLE;
                    end else begin
                        rel_inc   = step_rate(33'(env_level), release_len);
                        env_stage = STG_RELEASE;
                    end
                end
            end
            default: begin
                env_stage = STG_IDLE;
                env_level = '0;
            end
        endcase
        res.level  = LEVEL_OUT_W'(env_level >> Q23_SHIFT);
        res.shaped = scaled[SAMPLE_BITS_DEF-1:0];
        res.stage  = env_stage;
        res.last   = last;
        return res;
    endfunction

    // Per-cycle monitor: results are checked before a new input is predicted.
    always @(posedge i_clk) begin : monitor
        t_envelope_result want;
        if (!i_rst_n) begin
            reset_envelope();
            expected_results.delete();
        end else begin
            // Result transaction against the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, level", 32'(i_level_out), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_level_out !== want.level) begin
                        report_mismatch("level_out", 32'(i_level_out), 32'(want.level));
                    end
                    if (i_shaped_sample !== want.shaped) begin
                        report_mismatch("shaped_sample", 32'(i_shaped_sample), 32'(want.shaped));
                    end
                    if (i_stage_out !== want.stage) begin
                        report_mismatch("stage_out", 32'(i_stage_out), 32'(want.stage));
                    end
                    if (i_block_last !== want.last) begin
                        report_mismatch("block_last", 32'(i_block_last), 32'(want.last));
                    end
                end
            end

            // Input transaction: predict its result.
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_command(t_cmd'(i_cmd), i_audio_in,
                                                         i_block_end));
            end

            // Register access: writes update the prediction, reads are checked.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    write_register(t_reg'(i_paddr[3:2]), i_pwdata);
                end else if (i_prdata !== register_value(t_reg'(i_paddr[3:2]))) begin
                    report_mismatch("register read", i_prdata,
                                    register_value(t_reg'(i_paddr[3:2])));
                end
            end
        end
        o_fail_count <= mismatches + expected_results.size();
    end

endmodule

@@ verif/tb_adsr_envelope_generator_unit.sv @@
// Top of the ADSR envelope generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_adsr_envelope_generator_unit;
    import adsr_pkg::*;

    localparam int          SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam logic [31:0] TIME_CAP        = 32'd1 << TIME_BITS_DEF;
    localparam int          NUM_PHASES      = 6;
    localparam int          ITEMS_PER_PHASE = 230;
    localparam int          DRAIN_CYCLES    = 100;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd          = CMD_TICK;
    logic [SAMPLE_W-1:0]    audio        = '0;
    logic                   block_end    = 1'b0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [LEVEL_OUT_W-1:0] level_out;
    logic [SAMPLE_W-1:0]    shaped_sample;
    logic [STAGE_W-1:0]     stage_out;
    logic                   block_last;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int                     fail_count;

    int                     sender_idle_pct    = 0;
    int                     receiver_stall_pct = 0;
    int                     items_sent         = 0;
    int                     results_taken      = 0;

    // 10 ns clock.
    initial begin
        forever #5 clk = ~clk;
    end

    adsr_envelope_generator_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_audio_in      (audio),
        .i_block_end     (block_end),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_level_out     (level_out),
        .o_shaped_sample (shaped_sample),
        .o_stage_out     (stage_out),
        .o_block_last    (block_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    adsr_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_audio_in      (audio),
        .i_block_end     (block_end),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_level_out     (level_out),
        .i_shaped_sample (shaped_sample),
        .i_stage_out     (stage_out),
        .i_block_last    (block_last),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count)
    );

    // Count result transactions so the stimulus knows when the block is drained.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_taken <= results_taken + 1;
        end
    end

    // Random back-pressure on the result channel.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Offers one input transaction, with random gaps first, and waits for acceptance.
    task automatic send_item(input t_cmd c, input logic [SAMPLE_W-1:0] a, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = c;
        audio     = a;
        block_end = last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (results_taken != items_sent) begin
            @(posedge clk);
        end
    endtask

    // APB access: setup cycle, then access cycle until pready.
    task automatic apb_access(input t_reg r, input logic wr, input logic [APB_DATA_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = APB_ADDR_W'({r, 2'b00});
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes all four registers, then reads them back.
    task automatic configure(input logic [31:0] atk, input logic [31:0] dec,
                             input logic [31:0] sus, input logic [31:0] rel);
        apb_access(REG_ATTACK, 1'b1, atk);
        apb_access(REG_DECAY, 1'b1, dec);
        apb_access(REG_SUSTAIN, 1'b1, sus);
        apb_access(REG_RELEASE, 1'b1, rel);
        apb_access(REG_ATTACK, 1'b0, '0);
        apb_access(REG_DECAY, 1'b0, '0);
        apb_access(REG_SUSTAIN, 1'b0, '0);
        apb_access(REG_RELEASE, 1'b0, '0);
    endtask

    // Mostly short times so whole envelopes fit in a phase, sometimes the extremes.
    function automatic logic [31:0] pick_time();
        if ($urandom_range(9) != 0) begin
            return $urandom_range(12, 1);
        end
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return TIME_CAP;
            3:       return TIME_CAP + 32'd1;
            4:       return 32'h007F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_sustain();
        if ($urandom_range(9) > 2) begin
            return $urandom_range(Q23_ONE, 0);
        end
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'(Q23_ONE);
            2:       return 32'(Q23_ONE) + 32'd1;
            3:       return 32'h00FF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly ticks, with note events often enough to cycle through every stage.
    task automatic random_item();
        int   roll;
        t_cmd c;
        roll = $urandom_range(99);
        if (roll < 82) begin
            c = CMD_TICK;
        end else if (roll < 89) begin
            c = CMD_ON;
        end else if (roll < 97) begin
            c = CMD_OFF;
        end else begin
            c = CMD_RST;
        end
        send_item(c, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
    endtask

    // Run limit.
    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: read back, then a short envelope.
        apb_access(REG_ATTACK, 1'b0, '0);
        apb_access(REG_DECAY, 1'b0, '0);
        apb_access(REG_SUSTAIN, 1'b0, '0);
        apb_access(REG_RELEASE, 1'b0, '0);
        send_item(CMD_TICK, 24'h7F_FFFF, 1'b1);   // idle tick
        send_item(CMD_OFF, 24'h00_0000, 1'b0);    // note-off while idle is ignored
        send_item(CMD_ON, 24'h00_0000, 1'b0);
        send_item(CMD_TICK, 24'h7F_FFFF, 1'b0);
        send_item(CMD_TICK, 24'h80_0000, 1'b1);
        send_item(CMD_OFF, 24'hFF_FFFF, 1'b0);
        send_item(CMD_TICK, 24'hFF_FFFF, 1'b1);
        drop_valid();
        wait_drained();

        // Fastest attack, sustain above one, release time of zero.
        configure(32'd1, 32'd2, 32'h00FF_FFFF, 32'd0);
        send_item(CMD_ON, 24'h00_0000, 1'b0);
        send_item(CMD_OFF, 24'h00_0000, 1'b0);    // note-off at zero level goes idle
        send_item(CMD_ON, 24'h00_0000, 1'b0);
        send_item(CMD_TICK, 24'h7F_FFFF, 1'b1);   // reaches peak
        send_item(CMD_ON, 24'h12_3456, 1'b0);     // note-on at peak goes to decay
        send_item(CMD_TICK, 24'h80_0000, 1'b1);   // sustain at one is reached at once
        send_item(CMD_OFF, 24'h00_0000, 1'b0);
        send_item(CMD_TICK, 24'h7F_FFFF, 1'b0);
        send_item(CMD_TICK, 24'h80_0000, 1'b1);
        drop_valid();
        wait_drained();

        // Zero attack, oversized decay and release, sustain at zero.
        configure(32'd0, 32'h007F_FFFF, 32'd0, TIME_CAP + 32'd1);
        send_item(CMD_ON, 24'h00_0000, 1'b0);
        send_item(CMD_TICK, 24'h7F_FFFF, 1'b0);
        send_item(CMD_TICK, 24'h80_0000, 1'b1);
        send_item(CMD_OFF, 24'h00_0000, 1'b0);
        send_item(CMD_TICK, 24'hAA_5555, 1'b0);
        send_item(CMD_RST, 24'h00_0000, 1'b1);
        send_item(CMD_TICK, 24'h00_0000, 1'b0);

        // Random phases: two per idling pattern, new register settings in each.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drop_valid();
            wait_drained();
            case (p / 2)
                0: begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 60;
                end
                1: begin
                    sender_idle_pct    = 60;
                    receiver_stall_pct = 13;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            configure(pick_time(), pick_time(), pick_sustain(), pick_time());
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Once, the sender holds off until everything in flight has come out.
                if (p == 2 && k == ITEMS_PER_PHASE / 2) begin
                    drop_valid();
                    wait_drained();
                end
                random_item();
            end
        end

        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/adsr_pkg.sv
sv/adsr_div.sv
sv/adsr_envelope_generator_unit.sv
verif/adsr_checker.sv
verif/tb_adsr_envelope_generator_unit.sv
